/* hdl/dyts_pkg.sv */
// Shared types, constants and angle helpers of the dual yaw target splitter.
// Depends on nothing; every other file of the block imports it.

package dyts_pkg;

  // Width of the internal binary angles; a full turn is 2**ANGLE_BITS.
  localparam int ANGLE_BITS = 16;
  // Width in which magnitudes are compared against the 15-bit soft limit.
  localparam int CMP_W      = (ANGLE_BITS > 15) ? ANGLE_BITS : 15;
  // Width of the signed error times the unsigned Q0.16 gain.
  localparam int PROD_W     = ANGLE_BITS + 17;

  localparam int FIELD_W    = 16;
  localparam int LIMIT_W    = 15;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 2;

  typedef logic signed [ANGLE_BITS-1:0] angle_t;
  typedef logic        [ANGLE_BITS-1:0] angle_mag_t;
  typedef logic signed [FIELD_W-1:0]    field_t;
  typedef logic        [LIMIT_W-1:0]    limit_t;
  typedef logic        [GAIN_W-1:0]     gain_t;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMU_OFFSET  = 2'd0,
    REG_SMALL_ZERO  = 2'd1,
    REG_SOFT_LIMIT  = 2'd2,
    REG_FOLLOW_GAIN = 2'd3
  } cfg_reg_t;

  localparam field_t IMU_OFFSET_RST  = '0;
  localparam field_t SMALL_ZERO_RST  = '0;
  localparam limit_t SOFT_LIMIT_RST  = 15'd10695;
  localparam gain_t  FOLLOW_GAIN_RST = 16'd6554;

  // Current register settings, handed from the register file to the datapath.
  typedef struct packed {
    field_t imu_offset;
    field_t small_zero;
    limit_t soft_limit;
    gain_t  follow_gain;
  } cfg_t;

  typedef struct packed {
    field_t target_yaw;
    field_t imu_yaw;
    field_t small_encoder;
  } in_item_t;

  typedef struct packed {
    field_t big_target;
    field_t small_enc_target;
    field_t small_real;
    field_t big_real;
  } out_item_t;

  // Sign-extend or wrap a 16-bit field to the internal angle width.
  function automatic angle_t to_angle(field_t v);
    return angle_t'(v);
  endfunction

  // Sign-extend or truncate an internal angle to a 16-bit field.
  function automatic field_t to_field(angle_t v);
    return field_t'(v);
  endfunction

  // Magnitude of a signed angle; the half-turn value maps to 2**(ANGLE_BITS-1).
  function automatic angle_mag_t mag(angle_t v);
    angle_mag_t u;
    u = angle_mag_t'(v);
    return v[ANGLE_BITS-1] ? (~u + 1'b1) : u;
  endfunction

endpackage

/* hdl/dyts_ifs.sv */
// Handshake channel interfaces of the dual yaw target splitter.
// Depends on dyts_pkg for the field and index widths.

// Input channel: one control tick per item.
interface dyts_in_if import dyts_pkg::*; ();
  logic   valid;
  logic   ready;
  field_t target_yaw;
  field_t imu_yaw;
  field_t small_encoder;

  modport source (output valid, target_yaw, imu_yaw, small_encoder, input ready);
  modport sink   (input valid, target_yaw, imu_yaw, small_encoder, output ready);
endinterface

// Result channel: one result item per input item.
interface dyts_out_if import dyts_pkg::*; ();
  logic   valid;
  logic   ready;
  field_t big_target;
  field_t small_enc_target;
  field_t small_real;
  field_t big_real;

  modport source (output valid, big_target, small_enc_target, small_real, big_real,
                  input ready);
  modport sink   (input valid, big_target, small_enc_target, small_real, big_real,
                  output ready);
endinterface

// Configuration write channel.
interface dyts_cfg_if import dyts_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [FIELD_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/dyts_cfg_regs.sv */
// Configuration register file of the dual yaw target splitter.
// Depends on dyts_pkg and the dyts_cfg_if interface.

module dyts_cfg_regs import dyts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  dyts_cfg_if.sink    cfg_ch,
  output cfg_t        cfg
);

  // Writes are always taken.
  assign cfg_ch.ready = 1'b1;

  // Register writes, each masked to its own width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.imu_offset  <= IMU_OFFSET_RST;
      cfg.small_zero  <= SMALL_ZERO_RST;
      cfg.soft_limit  <= SOFT_LIMIT_RST;
      cfg.follow_gain <= FOLLOW_GAIN_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_IMU_OFFSET:  cfg.imu_offset  <= field_t'(cfg_ch.data);
        REG_SMALL_ZERO:  cfg.small_zero  <= field_t'(cfg_ch.data);
        REG_SOFT_LIMIT:  cfg.soft_limit  <= cfg_ch.data[LIMIT_W-1:0];
        REG_FOLLOW_GAIN: cfg.follow_gain <= cfg_ch.data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

/* hdl/dyts_split_core.sv */
// Combinational datapath of the dual yaw target splitter: stage angles,
// follow filter, soft-limit re-pins and the small-motor target.
// Depends on dyts_pkg.

module dyts_split_core import dyts_pkg::*; (
  input  cfg_t      cfg,
  input  in_item_t  item,
  input  angle_t    follow_target,
  input  logic      seeded,
  output angle_t    follow_target_next,
  output out_item_t result
);

  angle_t                   tgt, imu, enc, off, zero, lim_a;
  logic        [CMP_W-1:0]  lim_ext;
  angle_t                   small_real, big_real;
  angle_t                   ft_start, err, step, ft_follow;
  logic signed [PROD_W-1:0] prod, prod_rnd;
  angle_t                   r_diff, ft_cmd, m_diff, ft_meas;
  angle_t                   n_diff, need, smt;

  // Inputs and registers brought to the angle width.
  always_comb begin
    tgt     = to_angle(item.target_yaw);
    imu     = to_angle(item.imu_yaw);
    enc     = to_angle(item.small_encoder);
    off     = to_angle(cfg.imu_offset);
    zero    = to_angle(cfg.small_zero);
    lim_ext = CMP_W'(cfg.soft_limit);
    lim_a   = angle_t'(lim_ext[ANGLE_BITS-1:0]);
  end

  // Real global yaw of both stages.
  always_comb begin
    small_real = imu - off;
    big_real   = small_real + zero - enc;
  end

  // First-order follow with a rounded Q0.16 gain; the first item seeds the target.
  always_comb begin
    ft_start  = seeded ? follow_target : big_real;
    err       = tgt - ft_start;
    prod      = err * $signed({1'b0, cfg.follow_gain});
    prod_rnd  = prod + PROD_W'(1 << 15);
    step      = angle_t'(prod_rnd[ANGLE_BITS+15:16]);
    ft_follow = ft_start + step;
  end

  // Re-pin to the command, then to the measured relative angle.
  always_comb begin
    r_diff = tgt - ft_follow;
    if (CMP_W'(mag(r_diff)) > lim_ext) begin
      ft_cmd = r_diff[ANGLE_BITS-1] ? (tgt + lim_a) : (tgt - lim_a);
    end else begin
      ft_cmd = ft_follow;
    end
    m_diff = small_real - big_real;
    if (CMP_W'(mag(m_diff)) > lim_ext) begin
      ft_meas = m_diff[ANGLE_BITS-1] ? (small_real + lim_a) : (small_real - lim_a);
    end else begin
      ft_meas = ft_cmd;
    end
  end

  // Needed relative angle, clamped, gives the small-motor encoder target.
  always_comb begin
    n_diff = tgt - big_real;
    if (CMP_W'(mag(n_diff)) > lim_ext) begin
      need = n_diff[ANGLE_BITS-1] ? -lim_a : lim_a;
    end else begin
      need = n_diff;
    end
    smt = zero + need;
  end

  // Results.
  always_comb begin
    follow_target_next      = ft_meas;
    result.big_target       = to_field(ft_meas);
    result.small_enc_target = to_field(smt);
    result.small_real       = to_field(small_real);
    result.big_real         = to_field(big_real);
  end

endmodule

/* hdl/dual_yaw_target_splitter_top.sv */
// Dual yaw target splitter, top level.
// An accepted item is held in the input register, and its result is offered from
// the result register once the datapath result has been loaded there.
// Throughput: one item per cycle while the result channel is not stalled; the
// input register, the datapath and the result register form a two-stage pipeline,
// and the follow target is fed back through its own register for the next item.
// Reset (rst, synchronous) empties both stages, clears the follow target and
// its seed flag, and loads the register defaults.

module dual_yaw_target_splitter_top import dyts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  dyts_in_if.sink     in_ch,
  dyts_out_if.source  out_ch,
  dyts_cfg_if.sink    cfg_ch
);

  cfg_t      cfg;
  in_item_t  s1_data;
  logic      s1_valid;
  out_item_t out_data;
  logic      out_valid;
  angle_t    follow_target;
  angle_t    follow_target_next;
  logic      seeded;
  out_item_t result;
  logic      out_free, s1_adv, in_fire;

  dyts_cfg_regs u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  dyts_split_core u_core (
    .cfg                (cfg),
    .item               (s1_data),
    .follow_target      (follow_target),
    .seeded             (seeded),
    .follow_target_next (follow_target_next),
    .result             (result)
  );

  // Pipeline handshake: a stage moves on when the one after it is free.
  assign out_free    = !out_valid || out_ch.ready;
  assign s1_adv      = s1_valid && out_free;
  assign in_ch.ready = !s1_valid || out_free;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data.target_yaw    <= in_ch.target_yaw;
      s1_data.imu_yaw       <= in_ch.imu_yaw;
      s1_data.small_encoder <= in_ch.small_encoder;
    end
  end

  // Follow-target state, updated once per processed item.
  always_ff @(posedge clk) begin
    if (rst) begin
      follow_target <= '0;
      seeded        <= 1'b0;
    end else if (s1_adv) begin
      follow_target <= follow_target_next;
      seeded        <= 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data <= result;
    end
  end

  assign out_ch.valid            = out_valid;
  assign out_ch.big_target       = out_data.big_target;
  assign out_ch.small_enc_target = out_data.small_enc_target;
  assign out_ch.small_real       = out_data.small_real;
  assign out_ch.big_real         = out_data.big_real;

  // No result is offered right after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // Once an item has been processed the target counts as seeded.
  assert property (@(posedge clk) disable iff (rst) s1_adv |=> seeded)
    else $error("follow target not seeded after an item");

  // Before the first item the follow target keeps its reset value.
  assert property (@(posedge clk) disable iff (rst) !seeded |-> follow_target == '0)
    else $error("follow target moved before seeding");

  // A held input item is neither lost nor altered.
  assert property (@(posedge clk) disable iff (rst)
                   (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_data)))
    else $error("held input item changed");

  // The offered big target is the stored follow target of that item.
  assert property (@(posedge clk) disable iff (rst)
                   s1_adv |=> out_data.big_target == to_field(follow_target))
    else $error("big target differs from stored follow target");

endmodule
